FILE: src/word_modular_inverse_macros.svh
// ----------------------------------------------------------------------------
// word_modular_inverse_macros.svh
// Assertion macros shared by the modular inverse RTL.
// ----------------------------------------------------------------------------
`ifndef WORD_MODULAR_INVERSE_MACROS_SVH
`define WORD_MODULAR_INVERSE_MACROS_SVH

// same-cycle implication
`define WMI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WMI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/wmi_pkg.sv
// ----------------------------------------------------------------------------
// wmi_pkg
// Control word, status bundle and microprogram for the modular inverse.
// ----------------------------------------------------------------------------
package wmi_pkg;

    localparam int UPC_W = 3;

    // datapath operations
    localparam logic [2:0] OP_NOP      = 3'd0;
    localparam logic [2:0] OP_LOAD     = 3'd1;
    localparam logic [2:0] OP_DIV_INIT = 3'd2;
    localparam logic [2:0] OP_DIV_STEP = 3'd3;
    localparam logic [2:0] OP_UPDATE   = 3'd4;
    localparam logic [2:0] OP_FINAL    = 3'd5;

    // jump conditions
    localparam logic [2:0] COND_NEVER    = 3'd0;
    localparam logic [2:0] COND_ALWAYS   = 3'd1;
    localparam logic [2:0] COND_NO_REQ   = 3'd2;
    localparam logic [2:0] COND_DEN_LE1  = 3'd3;
    localparam logic [2:0] COND_CNT_NZ   = 3'd4;
    localparam logic [2:0] COND_OUT_BUSY = 3'd5;

    // microprogram addresses
    localparam logic [UPC_W-1:0] STEP_WAIT     = 3'd0;
    localparam logic [UPC_W-1:0] STEP_TEST     = 3'd1;
    localparam logic [UPC_W-1:0] STEP_DIV_INIT = 3'd2;
    localparam logic [UPC_W-1:0] STEP_DIV      = 3'd3;
    localparam logic [UPC_W-1:0] STEP_UPDATE   = 3'd4;
    localparam logic [UPC_W-1:0] STEP_FINAL    = 3'd5;
    localparam logic [UPC_W-1:0] STEP_RETURN   = 3'd6;

    typedef struct packed {
        logic [2:0]       op;
        logic [2:0]       cond;
        logic [UPC_W-1:0] target;
        logic             in_rdy;
    } t_ctl;

    typedef struct packed {
        logic den_le1;
        logic cnt_nz;
        logic out_busy;
    } t_stat;

    function automatic t_ctl rom_word(input logic [UPC_W-1:0] addr);
        t_ctl w;
        unique case (addr)
            STEP_WAIT:     w = '{OP_LOAD,     COND_NO_REQ,   STEP_WAIT,   1'b1};
            STEP_TEST:     w = '{OP_NOP,      COND_DEN_LE1,  STEP_FINAL,  1'b0};
            STEP_DIV_INIT: w = '{OP_DIV_INIT, COND_NEVER,    STEP_WAIT,   1'b0};
            STEP_DIV:      w = '{OP_DIV_STEP, COND_CNT_NZ,   STEP_DIV,    1'b0};
            STEP_UPDATE:   w = '{OP_UPDATE,   COND_ALWAYS,   STEP_TEST,   1'b0};
            STEP_FINAL:    w = '{OP_FINAL,    COND_OUT_BUSY, STEP_FINAL,  1'b0};
            STEP_RETURN:   w = '{OP_NOP,      COND_ALWAYS,   STEP_WAIT,   1'b0};
            default:       w = '{OP_NOP,      COND_ALWAYS,   STEP_WAIT,   1'b0};
        endcase
        return w;
    endfunction

endpackage

FILE: src/word_modular_inverse.sv
// ----------------------------------------------------------------------------
// word_modular_inverse
// Modular inverse of a word by the extended Euclidean algorithm.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall carries one request: i_value and
//   i_modulus. Output channel o_out_valid / i_out_stall returns i_value^-1
//   mod i_modulus on o_inverse, one result per request, in order.
//   A request is taken only when the sequencer sits at its wait step, so
//   one request is in flight at a time.
//   Each Euclid step runs test, divider setup, one serial one-bit
//   divide/multiply-add step per quotient bit of WORD_WIDTH, and update;
//   the serial divider dominates the time from acceptance of a request to
//   the earliest next acceptance.
//   The result sits in an output register; while the receiver stalls it
//   holds, and the next request is still taken and computed. The sequencer
//   waits at its final step only if the previous result is still unread.
//   Reset (synchronous, active low) returns the sequencer to its wait step,
//   holds o_in_stall high and drops o_out_valid.
// ----------------------------------------------------------------------------
module word_modular_inverse
    import wmi_pkg::*;
#(
    parameter int WORD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_value,
    input  logic [31:0] i_modulus,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_inverse
);

    t_ctl  ctl;
    t_stat stat;

    wmi_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    wmi_dp #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_in_valid  (i_in_valid),
        .i_value     (i_value),
        .i_modulus   (i_modulus),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_inverse   (o_inverse)
    );

    assign o_in_stall = !ctl.in_rdy || !i_rst_n;

endmodule

FILE: src/wmi_seq.sv
// ----------------------------------------------------------------------------
// wmi_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
`include "word_modular_inverse_macros.svh"

module wmi_seq
    import wmi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_ctl  o_ctl
);

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    logic             take;

    assign o_ctl = rom_word(r_upc);

    always_comb begin
        unique case (o_ctl.cond)
            COND_NEVER:    take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_REQ:   take = !i_in_valid;
            COND_DEN_LE1:  take = i_stat.den_le1;
            COND_CNT_NZ:   take = i_stat.cnt_nz;
            COND_OUT_BUSY: take = i_stat.out_busy;
            default:       take = 1'b1;
        endcase
        n_upc = take ? o_ctl.target : r_upc + UPC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= STEP_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

    `WMI_ASSERT_NEXT(a_accept_to_test, i_in_valid && o_ctl.in_rdy, r_upc == STEP_TEST, "request accepted but test step not next")
    `WMI_ASSERT_NOW(a_rdy_only_wait, o_ctl.in_rdy, r_upc == STEP_WAIT, "ready outside wait step")

endmodule

FILE: src/wmi_dp.sv
// ----------------------------------------------------------------------------
// wmi_dp
// Euclid datapath: serial divider with fused shift-add multiply,
// convergent registers and the result register.
// ----------------------------------------------------------------------------
`include "word_modular_inverse_macros.svh"

module wmi_dp
    import wmi_pkg::*;
#(
    parameter int WORD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    input  logic        i_in_valid,
    input  logic [31:0] i_value,
    input  logic [31:0] i_modulus,
    input  logic        i_out_stall,
    output t_stat       o_stat,
    output logic        o_out_valid,
    output logic [31:0] o_inverse
);

    localparam int W   = WORD_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     r_num, r_den, r_prev, r_cur, r_mod;
    logic [W-1:0]     r_rem, r_quo, r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_odd;
    logic             r_out_valid;
    logic [31:0]      r_inverse;

    logic [63:0]      val64, mod64, res64;
    logic [W-1:0]     val_w, mod_w, res_w;
    logic [W:0]       trial;
    logic [W:0]       trial_sub;
    logic             qbit;
    logic             out_busy;

    assign val64 = {32'b0, i_value};
    assign mod64 = {32'b0, i_modulus};
    assign val_w = val64[W-1:0];
    assign mod_w = mod64[W-1:0];

    assign trial     = {r_rem, r_quo[W-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign qbit      = !trial_sub[W];

    assign res_w = r_odd ? r_mod - r_cur : r_cur;
    always_comb begin
        res64        = '0;
        res64[W-1:0] = res_w;
    end

    assign out_busy        = r_out_valid && i_out_stall;
    assign o_stat.den_le1  = (r_den[W-1:1] == '0);
    assign o_stat.cnt_nz   = (r_cnt != '0);
    assign o_stat.out_busy = out_busy;

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_LOAD: begin
                if (i_in_valid) begin
                    r_num  <= val_w;
                    r_den  <= mod_w;
                    r_mod  <= mod_w;
                    r_prev <= W'(1);
                    r_cur  <= '0;
                    r_odd  <= 1'b1;
                end
            end
            OP_DIV_INIT: begin
                r_rem <= '0;
                r_quo <= r_num;
                r_acc <= '0;
                r_cnt <= CNT_W'(W - 1);
            end
            OP_DIV_STEP: begin
                // restoring divide; quotient bits also drive cur * q
                r_rem <= qbit ? trial_sub[W-1:0] : trial[W-1:0];
                r_quo <= {r_quo[W-2:0], qbit};
                r_acc <= {r_acc[W-2:0], 1'b0} + (qbit ? r_cur : '0);
                r_cnt <= r_cnt - CNT_W'(1);
            end
            OP_UPDATE: begin
                r_prev <= r_cur;
                r_cur  <= r_prev + r_acc;
                r_num  <= r_den;
                r_den  <= r_rem;
                r_odd  <= !r_odd;
            end
            OP_FINAL: begin
                if (!out_busy) begin
                    r_inverse <= res64[31:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.op == OP_FINAL && !out_busy) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_inverse   = r_inverse;

    `WMI_ASSERT_NOW(a_rem_below_den, i_ctl.op == OP_UPDATE, r_rem < r_den, "remainder not below divisor")
    `WMI_ASSERT_NEXT(a_final_loads_out, i_ctl.op == OP_FINAL && !out_busy, r_out_valid, "result not presented")

endmodule

FILE: test/tb_word_modular_inverse.sv
// ----------------------------------------------------------------------------
// tb_word_modular_inverse
// Self-checking bench for the extended Euclidean modular inverse. Requests
// are predicted in-bench by the continued-fraction recurrence at 32-bit
// wrap, then checked in order against the output channel. Directed cases
// cover zero values, unit moduli, unreduced and non-coprime inputs, word
// extremes and Fibonacci pairs (longest chains). Random traffic follows,
// under three sender/receiver pacing profiles.
// ----------------------------------------------------------------------------
module tb_word_modular_inverse;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 2000;
    localparam int MAX_PRINTED = 40;

    typedef struct {
        logic [31:0] value;
        logic [31:0] modulus;
        logic [31:0] inverse;
    } t_inverse_case;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_value     = '0;
    logic [31:0] i_modulus   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_inverse;

    t_inverse_case pending_inverses[$];
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int stall_burst     = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int quiet_cycles    = 0;

    word_modular_inverse #(.WORD_WIDTH(32)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .i_modulus   (i_modulus),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_inverse   (o_inverse)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [31:0] euclid_inverse(input logic [31:0] value,
                                                   input logic [31:0] modulus);
        logic [63:0] prev, cur, num, den, rem, nxt;
        bit          odd;
        prev = 64'd1;
        cur  = 64'd0;
        num  = 64'(value);
        den  = 64'(modulus);
        odd  = 1'b1;
        while (den > 64'd1) begin
            odd  = !odd;
            rem  = num % den;
            nxt  = (prev + cur * (num / den)) & 64'hFFFF_FFFF;
            prev = cur;
            cur  = nxt;
            num  = den;
            den  = rem;
        end
        if (odd)
            cur = (64'(modulus) - cur) & 64'hFFFF_FFFF;
        return cur[31:0];
    endfunction

    function automatic logic [31:0] fibonacci(input int k);
        logic [31:0] a, b, t;
        a = 32'd0;
        b = 32'd1;
        repeat (k) begin
            t = a + b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic send_request(input logic [31:0] value, input logic [31:0] modulus);
        int gap;
        gap = 0;
        if (send_idle_pct != 0) begin
            while ($urandom_range(99) < send_idle_pct)
                gap++;
            // occasional long gap so arrivals land at any point of a computation
            if ($urandom_range(7) == 0)
                gap += $urandom_range(1500, 1);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= value;
        i_modulus  <= modulus;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_inverses.push_back('{value, modulus, euclid_inverse(value, modulus)});
        requests_sent++;
    endtask

    task automatic idle_input;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic test_special_cases;
        send_request(32'd0, 32'd7);
        send_request(32'd0, 32'd1);
        send_request(32'd0, 32'hFFFF_FFFF);
        send_request(32'd5, 32'd1);
        send_request(32'hFFFF_FFFF, 32'd1);
        send_request(32'd100, 32'd7);
        send_request(32'hFFFF_FFFF, 32'd65537);
        send_request(32'd6, 32'd9);
        send_request(32'd12, 32'd18);
        send_request(32'hFFFF_FFFE, 32'hFFFF_FFFE);
        idle_input();
    endtask

    task automatic test_word_extremes;
        send_request(32'd1, 32'd2);
        send_request(32'd1, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_request(32'd3, 32'hFFFF_FFFB);
        send_request(32'h8000_0000, 32'hFFFF_FFFF);
        send_request(32'h7FFF_FFFF, 32'h8000_0000);
        send_request(32'h5555_5555, 32'hAAAA_AAAB);
        idle_input();
    endtask

    task automatic test_long_chains;
        send_request(fibonacci(46), fibonacci(47));
        send_request(fibonacci(47), fibonacci(46));
        send_request(fibonacci(45), fibonacci(46));
        send_request(fibonacci(20), fibonacci(21));
        idle_input();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        int          pick, k;
        logic [31:0] v, m;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                v = $urandom;
                m = $urandom_range(32'hFFFF_FFFF, 1);
            end else if (pick < 65) begin
                v = $urandom;
                m = $urandom_range(1000, 2);
            end else if (pick < 80) begin
                m = ($urandom_range(1) != 0) ? 32'hFFFF_FFFB : ($urandom | 32'd1);
                v = $urandom_range(m - 1, 1);
            end else if (pick < 92) begin
                k = $urandom_range(47, 3);
                m = fibonacci(k);
                v = fibonacci(k - 1);
                if ($urandom_range(3) == 0)
                    v = v + m;
            end else if ($urandom_range(1) != 0) begin
                v = 32'd0;
                m = $urandom_range(32'hFFFF_FFFF, 1);
            end else begin
                v = $urandom;
                m = 32'd1;
            end
            send_request(v, m);
        end
        idle_input();
    endtask

    always @(negedge i_clk) begin
        if (stall_burst > 0) begin
            i_out_stall <= 1'b1;
            stall_burst--;
        end else if (recv_stall_pct != 0 && $urandom_range(999) < 3) begin
            stall_burst = $urandom_range(400, 50);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_inverse_case head;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_inverses.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_inverse));
            end else begin
                head = pending_inverses.pop_front();
                results_checked++;
                if (o_inverse !== head.inverse)
                    report_mismatch($sformatf("inv(%h mod %h): got %h, want %h",
                        head.value, head.modulus, o_inverse, head.inverse));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no request or result moved for %0d cycles",
                         STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct  = 24;
        recv_stall_pct = 51;
        test_special_cases();
        test_word_extremes();
        test_long_chains();
        test_random(140, 24, 51);
        test_random(130, 51, 24);
        test_random(130, 0, 0);
        while (pending_inverses.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests (special, extreme, long-chain, random) over three pacing",
                 requests_sent);
        $display("profiles; %0d results checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/wmi_pkg.sv
src/wmi_seq.sv
src/wmi_dp.sv
src/word_modular_inverse.sv
test/tb_word_modular_inverse.sv
